@@ rtl/kpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared types, symbol codes and the seven-segment table for the keypad
// scanner and digit display.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int DEF_NUM_DIGITS = 6;
    localparam int DEF_NUM_COLS   = 4;

    localparam int ROW_W = 4;
    localparam int SEL_W = 8;
    localparam int SEG_W = 7;
    localparam int SYM_W = 4;

    typedef logic [SYM_W-1:0] t_sym;

    localparam t_sym SYM_DASH  = 4'd10;
    localparam t_sym SYM_BLANK = 4'd11;
    localparam t_sym SYM_NONE  = 4'd15;

    localparam logic [SEL_W-1:0] SEL_RESET = 8'h04;
    localparam logic [SEL_W-1:0] SEL_FIRST = 8'h02;

    typedef struct packed {
        logic pressed;
        t_sym sym;
    } t_key;

    function automatic logic [SEG_W-1:0] seg_code(input t_sym sym);
        logic [SEG_W-1:0] seg;
        case (sym)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            SYM_DASH: seg = 7'h40;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/kpsd_key_enc.sv @@
// ----------------------------------------------------------------------------
// kpsd_key_enc
// Priority encoder for the keypad rows: row 3 first, then row 2, then row 1,
// lowest column first, mapped to a display symbol.
// ----------------------------------------------------------------------------
module kpsd_key_enc #(
    parameter int NUM_COLS = kpsd_pkg::DEF_NUM_COLS
) (
    input  logic [kpsd_pkg::ROW_W-1:0] i_row_one_cols,
    input  logic [kpsd_pkg::ROW_W-1:0] i_row_two_cols,
    input  logic [kpsd_pkg::ROW_W-1:0] i_row_three_cols,
    output kpsd_pkg::t_key             o_key
);
    import kpsd_pkg::*;

    // first pressed column, 1-based, zero if none
    function automatic logic [2:0] first_col(input logic [ROW_W-1:0] cols);
        logic [2:0] col;
        col = 3'd0;
        for (int c = NUM_COLS - 1; c >= 0; c--) begin
            if (!cols[c]) begin
                col = 3'(c + 1);
            end
        end
        return col;
    endfunction

    logic [2:0] col_one;
    logic [2:0] col_two;
    logic [2:0] col_three;
    logic [3:0] key_num;

    always_comb begin
        col_one   = first_col(i_row_one_cols);
        col_two   = first_col(i_row_two_cols);
        col_three = first_col(i_row_three_cols);
        if (col_three != 3'd0) begin
            key_num = 4'd8 + {1'b0, col_three};
        end else if (col_two != 3'd0) begin
            key_num = 4'd4 + {1'b0, col_two};
        end else begin
            key_num = {1'b0, col_one};
        end

        o_key.pressed = (key_num != 4'd0);
        case (key_num)
            4'd10:   o_key.sym = t_sym'(0);
            4'd11:   o_key.sym = SYM_DASH;
            4'd12:   o_key.sym = SYM_BLANK;
            default: o_key.sym = key_num;
        endcase
    end

endmodule

@@ rtl/kpsd_disp.sv @@
// ----------------------------------------------------------------------------
// kpsd_disp
// Digit store, held-key memory, digit select ring and segment latch. All
// state moves on one advance per beat.
// ----------------------------------------------------------------------------
module kpsd_disp #(
    parameter int NUM_DIGITS = kpsd_pkg::DEF_NUM_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  kpsd_pkg::t_key             i_key,
    output logic [kpsd_pkg::SEL_W-1:0] o_digit_select,
    output logic [kpsd_pkg::SEG_W-1:0] o_segments
);
    import kpsd_pkg::*;

    t_sym             r_held;
    t_sym             n_held;
    t_sym             r_store [NUM_DIGITS];
    t_sym             n_store [NUM_DIGITS];
    logic [SEL_W-1:0] r_ring;
    logic [SEL_W-1:0] n_ring;
    logic [SEG_W-1:0] r_seg;
    logic [SEG_W-1:0] n_seg;

    always_comb begin
        n_held  = r_held;
        n_store = r_store;
        if (!i_key.pressed) begin
            n_held = SYM_NONE;
        end else if (i_key.sym != r_held) begin
            n_held = i_key.sym;
            for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                n_store[i] = r_store[i+1];
            end
            n_store[NUM_DIGITS-1] = i_key.sym;
        end

        n_ring = {r_ring[SEL_W-2:0], 1'b0};
        if (n_ring == '0) begin
            n_ring = SEL_FIRST;
        end

        // slots past the store and the idle slot hold the pattern
        n_seg = r_seg;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (n_ring[i+1]) begin
                n_seg = seg_code(n_store[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= SYM_NONE;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_store[i] <= SYM_BLANK;
            end
            r_ring <= SEL_RESET;
            r_seg  <= '0;
        end else if (i_adv) begin
            r_held  <= n_held;
            r_store <= n_store;
            r_ring  <= n_ring;
            r_seg   <= n_seg;
        end
    end

    assign o_digit_select = r_ring;
    assign o_segments     = r_seg;

endmodule

@@ rtl/keypad_scan_digit_display.sv @@
// Path: an accepted beat is held in the input register, then moves on to the
// result register, which drives the outputs.
// Throughput: one beat per cycle while the receiver does not stall; the input
// register hands on to the result register whenever that register is empty or being taken.
// Reset: synchronous, active low; store to blanks, no key held, select at 0x04,
// segments zero, both registers empty.
// ----------------------------------------------------------------------------
// keypad_scan_digit_display
// Matrix keypad scanner feeding a six-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
module keypad_scan_digit_display #(
    parameter int NUM_DIGITS = kpsd_pkg::DEF_NUM_DIGITS,
    parameter int NUM_COLS   = kpsd_pkg::DEF_NUM_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [kpsd_pkg::ROW_W-1:0] i_row_one_cols,
    input  logic [kpsd_pkg::ROW_W-1:0] i_row_two_cols,
    input  logic [kpsd_pkg::ROW_W-1:0] i_row_three_cols,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [kpsd_pkg::SEL_W-1:0] o_digit_select,
    output logic [kpsd_pkg::SEG_W-1:0] o_segments
);
    import kpsd_pkg::*;

    logic             r_in_valid;
    logic [ROW_W-1:0] r_row_one;
    logic [ROW_W-1:0] r_row_two;
    logic [ROW_W-1:0] r_row_three;
    logic             r_out_valid;
    logic             out_free;
    logic             adv;
    logic             in_take;
    t_key             key;

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take || adv) begin
                r_in_valid <= in_take;
            end
            if (out_free) begin
                r_out_valid <= adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_row_one   <= i_row_one_cols;
            r_row_two   <= i_row_two_cols;
            r_row_three <= i_row_three_cols;
        end
    end

    kpsd_key_enc #(
        .NUM_COLS(NUM_COLS)
    ) u_key_enc (
        .i_row_one_cols  (r_row_one),
        .i_row_two_cols  (r_row_two),
        .i_row_three_cols(r_row_three),
        .o_key           (key)
    );

    kpsd_disp #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_disp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_key         (key),
        .o_digit_select(o_digit_select),
        .o_segments    (o_segments)
    );

    assign o_valid = r_out_valid;

endmodule

@@ rtl/kpsd_checker.sv @@
// ----------------------------------------------------------------------------
// kpsd_checker
// Port-level checks on the keypad scanner and digit display.
// ----------------------------------------------------------------------------
module kpsd_checker #(
    parameter int NUM_DIGITS = kpsd_pkg::DEF_NUM_DIGITS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [kpsd_pkg::SEL_W-1:0] o_digit_select,
    input logic [kpsd_pkg::SEG_W-1:0] o_segments
);
    import kpsd_pkg::*;

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid after reset");

    // select is one-hot, never bit 0
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($onehot(o_digit_select) && !o_digit_select[0]))
        else $error("digit select not a legal slot");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digit_select)
                                  && $stable(o_segments)))
        else $error("stalled result beat changed");

    // segments only move with the select
    a_seg_with_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_segments) |-> !$stable(o_digit_select))
        else $error("segments changed without a select step");

    // idle slot keeps the previous pattern
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((NUM_DIGITS < 7) && $rose(o_digit_select[SEL_W-1])) |-> $stable(o_segments))
        else $error("segments changed in the idle slot");

endmodule

bind keypad_scan_digit_display kpsd_checker #(
    .NUM_DIGITS(NUM_DIGITS)
) u_kpsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digit_select(o_digit_select),
    .o_segments    (o_segments)
);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Keypad scanner and digit display testbench
// Feeds scan ticks of three active-low row readings through the valid/stall
// handshake and predicts every display beat (digit select and segments) from
// a behavioral copy of the key encoder, digit store, select ring and segment
// latch. Runs a directed set of key cases, then random keystroke sequences
// with noise, under three sender/receiver pacing mixes.
// ----------------------------------------------------------------------------
module testbench;

    import kpsd_pkg::*;

    localparam int N_DIGITS     = DEF_NUM_DIGITS;
    localparam int N_COLS       = DEF_NUM_COLS;
    localparam int RANDOM_TICKS = 830;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_TIME   = 4 * 400000;

    typedef struct packed {
        logic [ROW_W-1:0] row_one;
        logic [ROW_W-1:0] row_two;
        logic [ROW_W-1:0] row_three;
    } t_scan_tick;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [SEG_W-1:0] seg;
    } t_display_beat;

    localparam logic [SEG_W-1:0] SEGS_OF_SYM [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h40, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [ROW_W-1:0] i_row_one_cols = '1;
    logic [ROW_W-1:0] i_row_two_cols = '1;
    logic [ROW_W-1:0] i_row_three_cols = '1;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [SEL_W-1:0] o_digit_select;
    logic [SEG_W-1:0] o_segments;

    keypad_scan_digit_display dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_row_one_cols   (i_row_one_cols),
        .i_row_two_cols   (i_row_two_cols),
        .i_row_three_cols (i_row_three_cols),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digit_select   (o_digit_select),
        .o_segments       (o_segments)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_scan_tick    scan_queue [$];
    t_display_beat display_queue [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int beats_checked = 0;
    int keys_stored = 0;

    // behavioral copy of the display state
    t_sym             held_sym;
    t_sym             digit_model [N_DIGITS];
    logic [SEL_W-1:0] ring_model;
    logic [SEG_W-1:0] seg_model;

    function automatic int first_pressed_col(input logic [ROW_W-1:0] cols);
        for (int c = 0; c < N_COLS && c < ROW_W; c++) begin
            if (!cols[c]) return c + 1;
        end
        return 0;
    endfunction

    function automatic t_sym sym_of_key(input int key);
        if (key == 10) return t_sym'(0);
        if (key == 11) return SYM_DASH;
        if (key >= 12) return SYM_BLANK;
        return t_sym'(key);
    endfunction

    function automatic t_display_beat scan_and_display(input t_scan_tick t);
        int            key;
        int            col;
        t_sym          sym;
        t_display_beat beat;
        key = 0;
        col = first_pressed_col(t.row_three);
        if (col != 0) begin
            key = 8 + col;
        end else begin
            col = first_pressed_col(t.row_two);
            if (col != 0) begin
                key = 4 + col;
            end else begin
                col = first_pressed_col(t.row_one);
                if (col != 0) key = col;
            end
        end
        if (key == 0) begin
            held_sym = SYM_NONE;
        end else begin
            sym = sym_of_key(key);
            if (sym != held_sym) begin
                held_sym = sym;
                for (int i = 0; i + 1 < N_DIGITS; i++) digit_model[i] = digit_model[i+1];
                digit_model[N_DIGITS-1] = sym;
                keys_stored++;
            end
        end
        ring_model = ring_model << 1;
        if (ring_model == '0) ring_model = SEL_FIRST;
        for (int i = 0; i < 7; i++) begin
            if (ring_model == (SEL_W'(1) << (i + 1))) begin
                if (i < N_DIGITS) seg_model = SEGS_OF_SYM[digit_model[i]];
                break;
            end
        end
        beat.sel = ring_model;
        beat.seg = seg_model;
        return beat;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic add_scan(input logic [ROW_W-1:0] r1, input logic [ROW_W-1:0] r2,
                            input logic [ROW_W-1:0] r3);
        t_scan_tick t;
        t.row_one = r1;
        t.row_two = r2;
        t.row_three = r3;
        scan_queue.push_back(t);
    endtask

    // one key pressed for a few ticks, maybe with bounce on lower-priority
    // keys, then released for a few ticks
    task automatic add_keystroke(inout int count);
        logic [ROW_W-1:0] rv [3];
        int               row;
        int               col;
        int               hold;
        int               gap;
        logic [ROW_W-1:0] low_mask;
        row = $urandom_range(0, 2);
        col = $urandom_range(0, N_COLS - 1);
        hold = $urandom_range(1, 4);
        gap = $urandom_range(0, 3);
        low_mask = (ROW_W'(1) << col) - 1'b1;
        repeat (hold) begin
            rv[0] = '1;
            rv[1] = '1;
            rv[2] = '1;
            rv[row] = ~(ROW_W'(1) << col);
            if ($urandom_range(0, 99) < 40) begin
                rv[row] = (rv[row] & ROW_W'($urandom)) | low_mask;
                for (int r = 0; r < row; r++) rv[r] = ROW_W'($urandom);
            end
            add_scan(rv[0], rv[1], rv[2]);
            count++;
        end
        repeat (gap) begin
            add_scan('1, '1, '1);
            count++;
        end
    endtask

    task automatic add_random_ticks(input int target);
        int count;
        count = 0;
        while (count < target) begin
            if ($urandom_range(0, 99) < 75) begin
                add_keystroke(count);
            end else begin
                add_scan(ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom));
                count++;
            end
        end
    endtask

    task automatic add_directed_ticks();
        add_scan(4'b1111, 4'b1111, 4'b1111);
        for (int c = 0; c < N_COLS; c++) add_scan(~(4'b1 << c), 4'b1111, 4'b1111);
        for (int c = 0; c < N_COLS; c++) add_scan(4'b1111, ~(4'b1 << c), 4'b1111);
        for (int c = 0; c < N_COLS; c++) add_scan(4'b1111, 4'b1111, ~(4'b1 << c));
        // blank key held, then released and pressed again
        add_scan(4'b1111, 4'b1111, 4'b0111);
        add_scan(4'b1111, 4'b1111, 4'b1111);
        add_scan(4'b1111, 4'b1111, 4'b0111);
        // digit one held across two ticks
        add_scan(4'b1110, 4'b1111, 4'b1111);
        add_scan(4'b1110, 4'b1111, 4'b1111);
        // several keys at once
        add_scan(4'b0000, 4'b0000, 4'b0000);
        add_scan(4'b0000, 4'b1010, 4'b1111);
        add_scan(4'b1111, 4'b1111, 4'b0101);
        add_scan(4'b0110, 4'b1111, 4'b1111);
        add_scan(4'b1111, 4'b1111, 4'b1111);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_ticks,
                             input bit with_directed);
        @(negedge i_clk);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
        if (with_directed) add_directed_ticks();
        add_random_ticks(n_ticks);
        while (scan_queue.size() != 0 || display_queue.size() != 0) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_scan_tick t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                t.row_one = i_row_one_cols;
                t.row_two = i_row_two_cols;
                t.row_three = i_row_three_cols;
                display_queue.push_back(scan_and_display(t));
                ticks_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (scan_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t = scan_queue.pop_front();
                    i_valid <= 1'b1;
                    i_row_one_cols <= t.row_one;
                    i_row_two_cols <= t.row_two;
                    i_row_three_cols <= t.row_three;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_display_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (display_queue.size() == 0) begin
                    report_mismatch("unexpected beat, select", o_digit_select, 0);
                end else begin
                    want = display_queue.pop_front();
                    if (o_digit_select !== want.sel)
                        report_mismatch("digit_select", o_digit_select, want.sel);
                    if (o_segments !== want.seg)
                        report_mismatch("segments", o_segments, want.seg);
                    beats_checked++;
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        held_sym = SYM_NONE;
        for (int i = 0; i < N_DIGITS; i++) digit_model[i] = SYM_BLANK;
        ring_model = SEL_RESET;
        seg_model = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(22, 81, RANDOM_TICKS / 3, 1'b1);
        run_phase(81, 22, RANDOM_TICKS / 3, 1'b0);
        run_phase(0, 0, RANDOM_TICKS / 3, 1'b0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d display beats from %0d scan ticks, %0d keys stored,",
                 beats_checked, ticks_sent, keys_stored);
        $display("under sender-idle, receiver-stall and free-running pacing");
        if (mismatches == 0 && display_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("timeout with %0d beats outstanding", display_queue.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kpsd_pkg.sv
rtl/kpsd_key_enc.sv
rtl/kpsd_disp.sv
rtl/keypad_scan_digit_display.sv
rtl/kpsd_checker.sv
sim/testbench.sv
